@@ hdl/psl_pkg.sv @@
// Shared types and constants for the positional sorted list store.
package psl_pkg;

  // Field widths of the command and result transfers
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POSOUT_W = 6;
  localparam int CNT_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_SORTED = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_SET    = 3'd5,
    CMD_FIND   = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_FROM_LOWER,
    OP_FROM_UPPER
  } cell_op_t;

  // Compare results that a cell reports against the broadcast key
  typedef struct packed {
    logic eq;
    logic ge;
  } cell_flags_t;

endpackage

@@ hdl/psl_in_if.sv @@
// Command channel: valid/ready handshake with the command payload.
interface psl_in_if;
  logic                       valid;
  logic                       ready;
  logic [psl_pkg::CMD_W-1:0]   cmd;
  logic [psl_pkg::POS_W-1:0]   pos;
  logic [psl_pkg::VALUE_W-1:0] value;

  modport source(output valid, cmd, pos, value, input ready);
  modport sink(input valid, cmd, pos, value, output ready);
endinterface

@@ hdl/psl_out_if.sv @@
// Result channel: valid/ready handshake with the result payload.
interface psl_out_if;
  logic                        valid;
  logic                        ready;
  logic [psl_pkg::STATUS_W-1:0] status;
  logic [psl_pkg::POSOUT_W-1:0] position_out;
  logic [psl_pkg::VALUE_W-1:0]  read_value;
  logic [psl_pkg::CNT_W-1:0]    removed_count;
  logic [psl_pkg::CNT_W-1:0]    entry_count;

  modport source(output valid, status, position_out, read_value, removed_count, entry_count,
                 input ready);
  modport sink(input valid, status, position_out, read_value, removed_count, entry_count,
               output ready);
endinterface

@@ hdl/psl_cell.sv @@
// One list cell: holds an entry word, shifts with its neighbours, compares with the key.
module psl_cell #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  psl_pkg::cell_op_t    op,
  input  logic [WIDTH-1:0]     key,
  input  logic [WIDTH-1:0]     lower_word,
  input  logic [WIDTH-1:0]     upper_word,
  output logic [WIDTH-1:0]     word,
  output psl_pkg::cell_flags_t flags
);

  logic [WIDTH-1:0] word_r;

  // Load, shift or hold the entry
  always_ff @(posedge clk) begin
    unique case (op)
      psl_pkg::OP_LOAD:       word_r <= key;
      psl_pkg::OP_FROM_LOWER: word_r <= lower_word;
      psl_pkg::OP_FROM_UPPER: word_r <= upper_word;
      default:                word_r <= word_r;
    endcase
  end

  // Compare against the broadcast key, unsigned
  assign flags.eq = (word_r == key);
  assign flags.ge = (key <= word_r);
  assign word     = word_r;

endmodule

@@ hdl/psl_ctrl.sv @@
// Command sequencer: decodes a command, steers the cell row and registers the result.
module psl_ctrl #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  psl_in_if.sink               in_chan,
  psl_out_if.source            out_chan,
  input  psl_pkg::cell_flags_t flags [DEPTH],
  input  logic [WIDTH-1:0]     words [DEPTH],
  output logic [WIDTH-1:0]     key,
  output psl_pkg::cell_op_t    ops [DEPTH]
);

  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = psl_pkg::POS_W;
  localparam int CMP_W = (CW > PW) ? CW : PW;
  localparam int VW    = psl_pkg::VALUE_W;
  localparam int POW   = psl_pkg::POSOUT_W;
  localparam int NW    = psl_pkg::CNT_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;
  typedef enum logic [1:0] {MODE_HOLD, MODE_OPEN, MODE_CLOSE, MODE_WRITE} mode_t;

  state_t               state_r;
  psl_pkg::cmd_t        cmd_r;
  logic [PW-1:0]        pos_r;
  logic [WIDTH-1:0]     key_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        removed_r;
  logic                 out_valid_r;
  psl_pkg::status_t     status_r;
  logic [POW-1:0]       position_r;
  logic [VW-1:0]        read_r;
  logic [NW-1:0]        removed_out_r;
  logic [NW-1:0]        entry_out_r;

  logic [DEPTH-1:0]     live;
  logic [DEPTH-1:0]     f_eq;
  logic [DEPTH-1:0]     f_ge;
  logic [DEPTH-1:0]     pos_hot;
  logic [DEPTH-1:0]     pos_under;
  logic [DEPTH-1:0]     src;
  logic [DEPTH-1:0]     first;
  logic [DEPTH-1:0]     under_f;
  logic [IW-1:0]        first_idx;
  logic                 any_hit;
  logic                 full;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic [WIDTH-1:0]     rd_word;
  logic                 out_free;

  mode_t                mode;
  logic [DEPTH-1:0]     hit_sel;
  logic [DEPTH-1:0]     under_sel;
  logic                 finish;
  logic                 apply;
  psl_pkg::status_t     status_nxt;
  logic [IW-1:0]        where_nxt;
  logic [WIDTH-1:0]     rd_nxt;
  logic [CW-1:0]        count_nxt;
  logic [CW-1:0]        removed_nxt;

  // Binary index of a one-hot vector
  function automatic logic [IW-1:0] enc(input logic [DEPTH-1:0] oh);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (oh[i]) idx = idx | IW'(i);
    end
    return idx;
  endfunction

  // Per-cell masks: occupied cells, compare hits, position decode
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i]      = (CW'(i) < count_r);
      f_eq[i]      = flags[i].eq & live[i];
      f_ge[i]      = flags[i].ge & live[i];
      pos_hot[i]   = (CMP_W'(pos_r) == CMP_W'(i));
      pos_under[i] = (CMP_W'(i) < CMP_W'(pos_r));
    end
  end

  // Lowest hit: isolate the lowest set bit and the cells below it
  assign src       = (cmd_r == psl_pkg::CMD_SORTED) ? (f_ge | ~live) : f_eq;
  assign first     = src & (~src + DEPTH'(1));
  assign under_f   = (src - DEPTH'(1)) & ~src;
  assign first_idx = enc(first);
  assign any_hit   = |src;
  assign full      = (count_r == CW'(DEPTH));
  assign pos_ext   = CMP_W'(pos_r);
  assign cnt_ext   = CMP_W'(count_r);
  assign out_free  = !out_valid_r || out_chan.ready;

  // Select the addressed word for a get
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_hot[i]) rd_word = rd_word | words[i];
    end
  end

  // Decode the command into a row operation and a result
  always_comb begin
    mode        = MODE_HOLD;
    hit_sel     = pos_hot;
    under_sel   = pos_under;
    finish      = 1'b1;
    status_nxt  = psl_pkg::ST_OK;
    where_nxt   = '0;
    rd_nxt      = '0;
    count_nxt   = count_r;
    removed_nxt = removed_r;
    unique case (cmd_r)
      psl_pkg::CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_nxt = psl_pkg::ST_BAD;
        end else if (full) begin
          status_nxt = psl_pkg::ST_FULL;
        end else begin
          mode      = MODE_OPEN;
          where_nxt = IW'(pos_r);
          count_nxt = count_r + CW'(1);
        end
      end
      psl_pkg::CMD_SORTED: begin
        if (full) begin
          status_nxt = psl_pkg::ST_FULL;
        end else begin
          mode      = MODE_OPEN;
          hit_sel   = first;
          under_sel = under_f;
          where_nxt = first_idx;
          count_nxt = count_r + CW'(1);
        end
      end
      psl_pkg::CMD_ERASE: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt = psl_pkg::ST_BAD;
        end else begin
          mode      = MODE_CLOSE;
          count_nxt = count_r - CW'(1);
        end
      end
      psl_pkg::CMD_REMOVE: begin
        // Drop the lowest match each cycle until none is left
        if (any_hit) begin
          finish      = 1'b0;
          mode        = MODE_CLOSE;
          under_sel   = under_f;
          count_nxt   = count_r - CW'(1);
          removed_nxt = removed_r + CW'(1);
        end
      end
      psl_pkg::CMD_GET: begin
        if (pos_ext >= cnt_ext) status_nxt = psl_pkg::ST_BAD;
        else rd_nxt = rd_word;
      end
      psl_pkg::CMD_SET: begin
        if (pos_ext >= cnt_ext) status_nxt = psl_pkg::ST_BAD;
        else mode = MODE_WRITE;
      end
      psl_pkg::CMD_FIND: begin
        if (any_hit) where_nxt = first_idx;
        else status_nxt = psl_pkg::ST_BAD;
      end
      default: status_nxt = psl_pkg::ST_BAD;
    endcase
  end

  // A finishing step waits for a free result register; a removal step does not
  assign apply = (state_r == S_EXEC) && (finish ? out_free : 1'b1);

  // Per-cell operation from the mode and masks
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ops[i] = psl_pkg::OP_HOLD;
      if (apply) begin
        case (mode)
          MODE_OPEN: begin
            if (under_sel[i])    ops[i] = psl_pkg::OP_HOLD;
            else if (hit_sel[i]) ops[i] = psl_pkg::OP_LOAD;
            else                 ops[i] = psl_pkg::OP_FROM_LOWER;
          end
          MODE_CLOSE: begin
            if (!under_sel[i]) ops[i] = psl_pkg::OP_FROM_UPPER;
          end
          MODE_WRITE: begin
            if (hit_sel[i]) ops[i] = psl_pkg::OP_LOAD;
          end
          default: ops[i] = psl_pkg::OP_HOLD;
        endcase
      end
    end
  end

  // State, count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result on a finishing step, drop it once transferred
      if (apply && finish) out_valid_r <= 1'b1;
      else if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            state_r   <= S_EXEC;
            cmd_r     <= psl_pkg::cmd_t'(in_chan.cmd);
            pos_r     <= in_chan.pos;
            key_r     <= WIDTH'(in_chan.value);
            removed_r <= '0;
          end
        end
        S_EXEC: begin
          if (apply) begin
            count_r   <= count_nxt;
            removed_r <= removed_nxt;
            if (finish) begin
              state_r       <= S_IDLE;
              status_r      <= status_nxt;
              position_r    <= POW'(where_nxt);
              read_r        <= VW'(rd_nxt);
              removed_out_r <= NW'(removed_nxt);
              entry_out_r   <= NW'(count_nxt);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign key                    = key_r;
  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.position_out  = position_r;
  assign out_chan.read_value    = read_r;
  assign out_chan.removed_count = removed_out_r;
  assign out_chan.entry_count   = entry_out_r;

endmodule

@@ hdl/positional_sorted_list_store_unit.sv @@
// A command is taken into the command registers, then executes in the cell row;
// its result is registered with the row update, once the result register is free.
// Remove-equal erases one match per step (one erase per cycle) until none is left.
// A new command is taken only after the current one has finished in the cell row.
// Reset (synchronous, active low) empties the list and clears the handshake;
// the entry words themselves are not cleared and are never read until written.
module positional_sorted_list_store_unit #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  psl_in_if.sink    in_chan,
  psl_out_if.source out_chan
);

  logic [WIDTH-1:0]     words [DEPTH];
  psl_pkg::cell_flags_t flags [DEPTH];
  psl_pkg::cell_op_t    ops   [DEPTH];
  logic [WIDTH-1:0]     key;

  // Row of cells, each wired to its neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] lower_word;
    logic [WIDTH-1:0] upper_word;

    if (i == 0) begin : g_first
      assign lower_word = words[i];
    end else begin : g_mid_lo
      assign lower_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_word = words[i];
    end else begin : g_mid_hi
      assign upper_word = words[i+1];
    end

    psl_cell #(.WIDTH(WIDTH)) u_cell (
      .clk        (clk),
      .op         (ops[i]),
      .key        (key),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .word       (words[i]),
      .flags      (flags[i])
    );
  end

  psl_ctrl #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .flags    (flags),
    .words    (words),
    .key      (key),
    .ops      (ops)
  );

endmodule

@@ hdl/psl_checker.sv @@
// Port-level checks for the positional sorted list store, bound to the top level.
module psl_checker #(
  parameter int DEPTH = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [psl_pkg::STATUS_W-1:0]  out_status,
  input logic [psl_pkg::POSOUT_W-1:0]  out_position_out,
  input logic [psl_pkg::VALUE_W-1:0]   out_read_value,
  input logic [psl_pkg::CNT_W-1:0]     out_removed_count,
  input logic [psl_pkg::CNT_W-1:0]     out_entry_count
);

  localparam int NW = psl_pkg::CNT_W;

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_position_out) && $stable(out_read_value) &&
      $stable(out_removed_count) && $stable(out_entry_count))
    else $error("stalled result changed");

  // One command at a time: no transfer on the edge after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // A full report only comes with a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == psl_pkg::ST_FULL |-> out_entry_count == NW'(DEPTH))
    else $error("full status with list not full");

  // Removals are only reported on success
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_removed_count != '0 |-> out_status == psl_pkg::ST_OK)
    else $error("removed count with failing status");

endmodule

bind positional_sorted_list_store_unit psl_checker #(.DEPTH(DEPTH)) u_psl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_status        (out_chan.status),
  .out_position_out  (out_chan.position_out),
  .out_read_value    (out_chan.read_value),
  .out_removed_count (out_chan.removed_count),
  .out_entry_count   (out_chan.entry_count)
);
